>>> design/tss_pkg.sv
// Package for the two-stack shared buffer: operation codes, status codes
// and the controller state type. No dependencies.
`timescale 1ns / 1ps

package tss_pkg;

  // Data word width of one stack entry.
  localparam int unsigned WORD_W = 32;

  // Operation codes carried by an input item.
  typedef enum logic [2:0] {
    OP_PUSH_ONE = 3'd0,
    OP_PUSH_TWO = 3'd1,
    OP_POP_ONE  = 3'd2,
    OP_POP_TWO  = 3'd3,
    OP_DUMP_ONE = 3'd4,
    OP_DUMP_TWO = 3'd5
  } op_t;

  // Result status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // Controller states: idle and ready for an item, or streaming read data.
  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_DATA = 1'b1
  } state_t;

endpackage

>>> design/tss_mem.sv
// Synchronous word memory shared by both stacks: one write port and one
// read port with registered read data. Depends on tss_pkg.
`timescale 1ns / 1ps

module tss_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [AW-1:0]                     wr_addr,
  input  logic signed [tss_pkg::WORD_W-1:0] wr_data,
  input  logic                              rd_en,
  input  logic [AW-1:0]                     rd_addr,
  output logic signed [tss_pkg::WORD_W-1:0] rd_data
);

  logic signed [tss_pkg::WORD_W-1:0] mem_q [DEPTH];
  logic signed [tss_pkg::WORD_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  // Read port; the data register holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_q[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/tss_ctrl.sv
// Controller for the two-stack shared buffer: stack counts, operation
// decode, memory access sequencing and the result register. Depends on tss_pkg.
`timescale 1ns / 1ps

module tss_ctrl #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned CW    = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        in_operation,
  input  logic signed [tss_pkg::WORD_W-1:0] in_push_value,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic                              out_has_data,
  output logic signed [tss_pkg::WORD_W-1:0] out_data_value,
  output logic                              out_last,
  // Memory port.
  output logic                              mem_wr_en,
  output logic [AW-1:0]                     mem_wr_addr,
  output logic signed [tss_pkg::WORD_W-1:0] mem_wr_data,
  output logic                              mem_rd_en,
  output logic [AW-1:0]                     mem_rd_addr,
  input  logic signed [tss_pkg::WORD_W-1:0] mem_rd_data
);

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  tss_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   lower_count_r, lower_count_nxt;
  logic [CW-1:0]   upper_count_r, upper_count_nxt;
  logic [CW-1:0]   remain_r, remain_nxt;
  logic [AW-1:0]   rd_addr_r, rd_addr_nxt;
  logic            down_r, down_nxt;

  logic                              out_valid_r, out_valid_nxt;
  logic [1:0]                        out_status_r, out_status_nxt;
  logic                              out_has_data_r, out_has_data_nxt;
  logic signed [tss_pkg::WORD_W-1:0] out_data_value_r, out_data_value_nxt;
  logic                              out_last_r, out_last_nxt;

  logic          out_free;
  logic          accept;
  logic          full;
  logic [CW-1:0] lower_top;
  logic [CW-1:0] upper_top;
  logic [CW-1:0] upper_free;
  logic          load_out;
  logic [1:0]    load_status;
  logic          load_has_data;
  logic          load_last;

  // The result register can take a new item when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == tss_pkg::ST_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;

  // Stack geometry: top entries and the next free entry of stack two.
  assign full       = ((CW+1)'(lower_count_r) + (CW+1)'(upper_count_r)) >= (CW+1)'(DEPTH);
  assign lower_top  = lower_count_r - CW'(1);
  assign upper_top  = DEPTH_C - upper_count_r;
  assign upper_free = DEPTH_C - upper_count_r - CW'(1);

  // Next state, memory access and result loading.
  always_comb begin
    state_nxt       = state_r;
    lower_count_nxt = lower_count_r;
    upper_count_nxt = upper_count_r;
    remain_nxt      = remain_r;
    rd_addr_nxt     = rd_addr_r;
    down_nxt        = down_r;
    mem_wr_en       = 1'b0;
    mem_wr_addr     = lower_count_r[AW-1:0];
    mem_wr_data     = in_push_value;
    mem_rd_en       = 1'b0;
    mem_rd_addr     = rd_addr_r;
    load_out        = 1'b0;
    load_status     = tss_pkg::STAT_OK;
    load_has_data   = 1'b0;
    load_last       = 1'b1;

    unique case (state_r)
      tss_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (tss_pkg::op_t'(in_operation))
            tss_pkg::OP_PUSH_ONE: begin
              load_out = 1'b1;
              if (full) begin
                load_status = tss_pkg::STAT_FULL;
              end else begin
                mem_wr_en       = 1'b1;
                mem_wr_addr     = lower_count_r[AW-1:0];
                lower_count_nxt = lower_count_r + CW'(1);
              end
            end
            tss_pkg::OP_PUSH_TWO: begin
              load_out = 1'b1;
              if (full) begin
                load_status = tss_pkg::STAT_FULL;
              end else begin
                mem_wr_en       = 1'b1;
                mem_wr_addr     = upper_free[AW-1:0];
                upper_count_nxt = upper_count_r + CW'(1);
              end
            end
            tss_pkg::OP_POP_ONE: begin
              if (lower_count_r == '0) begin
                load_out    = 1'b1;
                load_status = tss_pkg::STAT_EMPTY;
              end else begin
                mem_rd_en       = 1'b1;
                mem_rd_addr     = lower_top[AW-1:0];
                rd_addr_nxt     = lower_top[AW-1:0];
                lower_count_nxt = lower_top;
                remain_nxt      = '0;
                state_nxt       = tss_pkg::ST_DATA;
              end
            end
            tss_pkg::OP_POP_TWO: begin
              if (upper_count_r == '0) begin
                load_out    = 1'b1;
                load_status = tss_pkg::STAT_EMPTY;
              end else begin
                mem_rd_en       = 1'b1;
                mem_rd_addr     = upper_top[AW-1:0];
                rd_addr_nxt     = upper_top[AW-1:0];
                upper_count_nxt = upper_count_r - CW'(1);
                remain_nxt      = '0;
                state_nxt       = tss_pkg::ST_DATA;
              end
            end
            tss_pkg::OP_DUMP_ONE: begin
              if (lower_count_r == '0) begin
                load_out = 1'b1;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = lower_top[AW-1:0];
                rd_addr_nxt = lower_top[AW-1:0];
                remain_nxt  = lower_top;
                down_nxt    = 1'b1;
                state_nxt   = tss_pkg::ST_DATA;
              end
            end
            tss_pkg::OP_DUMP_TWO: begin
              if (upper_count_r == '0) begin
                load_out = 1'b1;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = upper_top[AW-1:0];
                rd_addr_nxt = upper_top[AW-1:0];
                remain_nxt  = upper_count_r - CW'(1);
                down_nxt    = 1'b0;
                state_nxt   = tss_pkg::ST_DATA;
              end
            end
            default: begin
              // Unused codes are consumed without a result.
            end
          endcase
        end
      end
      tss_pkg::ST_DATA: begin
        // When the result register is free, hand it the read word and fetch the next one unless it was the last.
        if (out_free) begin
          load_out      = 1'b1;
          load_has_data = 1'b1;
          load_last     = (remain_r == '0);
          if (remain_r == '0) begin
            state_nxt = tss_pkg::ST_IDLE;
          end else begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = down_r ? (rd_addr_r - AW'(1)) : (rd_addr_r + AW'(1));
            rd_addr_nxt = mem_rd_addr;
            remain_nxt  = remain_r - CW'(1);
          end
        end
      end
      default: begin
        state_nxt = tss_pkg::ST_IDLE;
      end
    endcase
  end

  // Result register next values.
  always_comb begin
    out_status_nxt     = out_status_r;
    out_has_data_nxt   = out_has_data_r;
    out_data_value_nxt = out_data_value_r;
    out_last_nxt       = out_last_r;
    if (load_out) begin
      out_valid_nxt      = 1'b1;
      out_status_nxt     = load_status;
      out_has_data_nxt   = load_has_data;
      out_data_value_nxt = load_has_data ? mem_rd_data : '0;
      out_last_nxt       = load_last;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= tss_pkg::ST_IDLE;
      lower_count_r <= '0;
      upper_count_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      lower_count_r <= lower_count_nxt;
      upper_count_r <= upper_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Sequencing and payload registers.
  always_ff @(posedge clk) begin
    remain_r         <= remain_nxt;
    rd_addr_r        <= rd_addr_nxt;
    down_r           <= down_nxt;
    out_status_r     <= out_status_nxt;
    out_has_data_r   <= out_has_data_nxt;
    out_data_value_r <= out_data_value_nxt;
    out_last_r       <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_has_data   = out_has_data_r;
  assign out_data_value = out_data_value_r;
  assign out_last       = out_last_r;

endmodule

>>> design/two_stacks_shared_buffer_top.sv
// Two LIFO stacks in one shared memory of DEPTH words.
// Push, empty pop and empty dump: the result is registered in the cycle after acceptance.
// Unused codes: accepted and give no result.
// Pop: one memory read, then the word goes to the result register; next item after the result.
// Dump of n words: one result per cycle behind the memory read port while out_stall is low.
// Reset clears both stack counts and the result valid flag; memory is not cleared.
`timescale 1ns / 1ps

module two_stacks_shared_buffer_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        in_operation,
  input  logic signed [tss_pkg::WORD_W-1:0] in_push_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic                              out_has_data,
  output logic signed [tss_pkg::WORD_W-1:0] out_data_value,
  output logic                              out_last
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                              mem_wr_en;
  logic [AW-1:0]                     mem_wr_addr;
  logic signed [tss_pkg::WORD_W-1:0] mem_wr_data;
  logic                              mem_rd_en;
  logic [AW-1:0]                     mem_rd_addr;
  logic signed [tss_pkg::WORD_W-1:0] mem_rd_data;

  // Stack controller.
  tss_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_push_value  (in_push_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_has_data   (out_has_data),
    .out_data_value (out_data_value),
    .out_last       (out_last),
    .mem_wr_en      (mem_wr_en),
    .mem_wr_addr    (mem_wr_addr),
    .mem_wr_data    (mem_wr_data),
    .mem_rd_en      (mem_rd_en),
    .mem_rd_addr    (mem_rd_addr),
    .mem_rd_data    (mem_rd_data)
  );

  // Shared word memory.
  tss_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule
